/* rtl/core/spq_pkg.sv */
// Shared types and constants for the three-level strict priority queue.
// Holds the field widths, the result status codes and the controller command bundle.
// No dependencies.
package spq_pkg;

	// Payload field widths.
	localparam int ID_W    = 16;
	localparam int PRIO_W  = 2;
	localparam int CMD_W   = 1;
	localparam int TOTAL_W = 6;
	localparam int STAT_W  = 2;

	// Default geometry.
	localparam int DEPTH_DEF  = 16;
	localparam int LEVELS_DEF = 3;

	// Command codes carried by an input item.
	localparam logic [CMD_W-1:0] CMD_ENQ = 1'b0;
	localparam logic [CMD_W-1:0] CMD_DEQ = 1'b1;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_ENQ   = 2'd0;
	localparam logic [STAT_W-1:0] ST_DEQ   = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_DROP  = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;  // capture the accepted input item
		logic exec;   // decide, update pointers and access the store
		logic load;   // move the result into the output register
	} spq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic busy;   // an item has been captured and not yet handed to the output
	} spq_sts_t;

endpackage

/* rtl/core/spq_ctrl.sv */
// Sequencing controller for the strict priority queue.
// Walks each item through capture, execute and output load, and owns the output valid flag.
// Depends on spq_pkg.
module spq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  spq_pkg::spq_sts_t sts,
	output spq_pkg::spq_cmd_t cmd
);
	import spq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// The output register can take a new result when empty or being drained.
	assign out_free = !out_valid_q || m_tready;

	// Command decode from the current state.
	always_comb begin
		cmd       = '0;
		cmd.latch = (state_q == S_IDLE) && s_tvalid;
		cmd.exec  = (state_q == S_EXEC);
		cmd.load  = (state_q == S_DONE) && out_free;
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;

	// State and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// An accepted item always goes on to the execute step.
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == S_EXEC)
		else $error("accepted item did not move to execute");

	// A new result only appears straight after the output load step.
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_DONE))
		else $error("output valid rose without a load");

	// The datapath reports an item in flight whenever the controller is past capture.
	a_busy_track: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> sts.busy)
		else $error("controller and datapath disagree on item in flight");

	// At most one command is issued in any cycle.
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("overlapping datapath commands");

endmodule

/* rtl/core/spq_datapath.sv */
// Datapath of the strict priority queue: per-level pointers and counts, the entry store,
// the level search and the output register.
// Depends on spq_pkg.
module spq_datapath #(
	parameter int DEPTH  = spq_pkg::DEPTH_DEF,
	parameter int LEVELS = spq_pkg::LEVELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  spq_pkg::spq_cmd_t           cmd,
	output spq_pkg::spq_sts_t           sts,
	input  logic [spq_pkg::CMD_W-1:0]   in_command,
	input  logic [spq_pkg::PRIO_W-1:0]  in_priority,
	input  logic [spq_pkg::ID_W-1:0]    in_id,
	output logic [spq_pkg::STAT_W-1:0]  out_status,
	output logic [spq_pkg::ID_W-1:0]    out_id,
	output logic [spq_pkg::PRIO_W-1:0]  out_priority,
	output logic [spq_pkg::TOTAL_W-1:0] out_total
);
	import spq_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int LVL_W = $clog2(LEVELS);
	localparam int MEM_N = LEVELS << PTR_W;
	localparam int ADR_W = LVL_W + PTR_W;

	// Captured input item.
	logic [CMD_W-1:0]   cmd_q;
	logic [PRIO_W-1:0]  prio_q;
	logic [ID_W-1:0]    id_q;
	logic               busy_q;

	// Per-level queue state.
	logic [PTR_W-1:0]   head_q [LEVELS];
	logic [PTR_W-1:0]   tail_q [LEVELS];
	logic [CNT_W-1:0]   count_q [LEVELS];
	logic [TOTAL_W-1:0] total_q;

	// Result of the execute step, waiting for the output load.
	logic [STAT_W-1:0]  res_status_q;
	logic [PRIO_W-1:0]  res_prio_q;

	// Entry store and its registered read data.
	logic [ID_W-1:0]    mem [MEM_N];
	logic [ID_W-1:0]    rd_data_q;

	// Output register.
	logic [STAT_W-1:0]  out_status_q;
	logic [ID_W-1:0]    out_id_q;
	logic [PRIO_W-1:0]  out_prio_q;
	logic [TOTAL_W-1:0] out_total_q;

	// Decision logic.
	logic [PRIO_W-1:0]  prio_m1;
	logic [LVL_W-1:0]   enq_lvl;
	logic               prio_ok;
	logic               lvl_full;
	logic [LVL_W-1:0]   deq_lvl;
	logic               found;
	logic               wr_en;
	logic               rd_en;
	logic [ADR_W-1:0]   wr_addr;
	logic [ADR_W-1:0]   rd_addr;
	logic [PTR_W-1:0]   tail_next;
	logic [PTR_W-1:0]   head_next;

	// Enqueue level check: priority must name an existing level.
	assign prio_m1  = prio_q - PRIO_W'(1);
	assign enq_lvl  = LVL_W'(prio_m1);
	assign prio_ok  = (prio_q != '0) && (32'(prio_q) <= LEVELS);
	assign lvl_full = prio_ok && (count_q[enq_lvl] == CNT_W'(DEPTH));

	// Most urgent non-empty level; the lowest index wins.
	always_comb begin
		found   = 1'b0;
		deq_lvl = '0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (count_q[i] != '0) begin
				found   = 1'b1;
				deq_lvl = LVL_W'(i);
			end
		end
	end

	assign wr_en     = cmd.exec && (cmd_q == CMD_ENQ) && prio_ok && !lvl_full;
	assign rd_en     = cmd.exec && (cmd_q == CMD_DEQ) && found;
	assign wr_addr   = {enq_lvl, tail_q[enq_lvl]};
	assign rd_addr   = {deq_lvl, head_q[deq_lvl]};
	assign tail_next = (tail_q[enq_lvl] == PTR_W'(DEPTH - 1)) ? '0
		: tail_q[enq_lvl] + PTR_W'(1);
	assign head_next = (head_q[deq_lvl] == PTR_W'(DEPTH - 1)) ? '0
		: head_q[deq_lvl] + PTR_W'(1);

	// Entry store: at most one write or one registered read per cycle, only in the execute step.
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= id_q;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	// Input capture and result payload registers.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			cmd_q  <= in_command;
			prio_q <= in_priority;
			id_q   <= in_id;
		end
		if (cmd.exec) begin
			if (cmd_q == CMD_ENQ) begin
				res_status_q <= wr_en ? ST_ENQ : ST_DROP;
				res_prio_q   <= '0;
			end else begin
				res_status_q <= found ? ST_DEQ : ST_EMPTY;
				res_prio_q   <= found ? PRIO_W'(deq_lvl) + PRIO_W'(1) : '0;
			end
		end
		if (cmd.load) begin
			out_status_q <= res_status_q;
			out_id_q     <= (res_status_q == ST_DEQ) ? rd_data_q : '0;
			out_prio_q   <= res_prio_q;
			out_total_q  <= total_q;
		end
	end

	// Pointers, counts and the item-in-flight flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
			total_q <= '0;
			busy_q  <= 1'b0;
		end else begin
			if (cmd.latch) begin
				busy_q <= 1'b1;
			end else if (cmd.load) begin
				busy_q <= 1'b0;
			end
			if (wr_en) begin
				tail_q[enq_lvl]  <= tail_next;
				count_q[enq_lvl] <= count_q[enq_lvl] + CNT_W'(1);
				total_q          <= total_q + TOTAL_W'(1);
			end
			if (rd_en) begin
				head_q[deq_lvl]  <= head_next;
				count_q[deq_lvl] <= count_q[deq_lvl] - CNT_W'(1);
				total_q          <= total_q - TOTAL_W'(1);
			end
		end
	end

	assign sts.busy     = busy_q;
	assign out_status   = out_status_q;
	assign out_id       = out_id_q;
	assign out_priority = out_prio_q;
	assign out_total    = out_total_q;

	// The store is never written and read in the same cycle.
	a_no_wr_rd: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("store written and read together");

	// A level never holds more than its depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> count_q[enq_lvl] < CNT_W'(DEPTH))
		else $error("enqueue into a full level");

	// A dequeue leaves its level one entry lighter.
	a_deq_count: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> count_q[$past(deq_lvl)] == $past(count_q[deq_lvl]) - CNT_W'(1))
		else $error("dequeue did not reduce level count");

endmodule

/* rtl/core/three_level_strict_priority_queue_top.sv */
// Strict priority queue with LEVELS FIFO levels of DEPTH entries each, level 1 most urgent.
// Once an input item is accepted, the controller steps through the execute state, then the
// load state, which waits while the output still holds a result not yet taken. No new item
// is accepted before that load; the execute-step store read is registered for the load step.
// Reset (arst_n low, asynchronous) empties every level and drops any result waiting at the
// output; the entry store is not cleared and needs no clearing pass.
module three_level_strict_priority_queue_top #(
	parameter int DEPTH  = spq_pkg::DEPTH_DEF,
	parameter int LEVELS = spq_pkg::LEVELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [1:0] priority_req, [17:2] item_id, [23:18] zero
	input  logic        s_tuser,   // [0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [15:0] out_id, [17:16] out_priority, [23:18] total_count
	output logic [1:0]  m_tuser    // [1:0] status
);
	import spq_pkg::*;

	spq_cmd_t           cmd;
	spq_sts_t           sts;
	logic [ID_W-1:0]    res_id;
	logic [PRIO_W-1:0]  res_prio;
	logic [TOTAL_W-1:0] res_total;
	logic [STAT_W-1:0]  res_status;

	// Sequencing controller.
	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Queue state, entry store and output register.
	spq_datapath #(
		.DEPTH  (DEPTH),
		.LEVELS (LEVELS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_command   (s_tuser),
		.in_priority  (s_tdata[1:0]),
		.in_id        (s_tdata[17:2]),
		.out_status   (res_status),
		.out_id       (res_id),
		.out_priority (res_prio),
		.out_total    (res_total)
	);

	assign m_tdata = {res_total, res_prio, res_id};
	assign m_tuser = res_status;

endmodule
